// ----- design/command_record_framer_macros.svh -----
// ---------------------------------------------------------------------------
// command_record_framer assertion macros
// Concurrent assertion shorthands on clk with rst_n low as disable.
// ---------------------------------------------------------------------------
`ifndef COMMAND_RECORD_FRAMER_MACROS_SVH
`define COMMAND_RECORD_FRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define CMDFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmdfr: same-cycle check failed");

// Next-cycle implication.
`define CMDFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmdfr: next-cycle check failed");

`else

`define CMDFR_ASSERT_IMP(lbl, ante, cons)
`define CMDFR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/cmdfr_pkg.sv -----
// ---------------------------------------------------------------------------
// cmdfr_pkg
// Shared types, codes and constants of the command record framer.
// ---------------------------------------------------------------------------
package cmdfr_pkg;

    localparam int BUFFER_DEPTH = 2048;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = ADDR_W;
    localparam int HAVE_W       = CNT_W + 1;
    localparam int LEN_W        = 18;
    localparam int CMP_W        = 24;

    // field widths
    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int STATUS_W = 3;
    localparam int OLEN_W   = 11;
    localparam int CREG_W   = 7;
    localparam int CIDX_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_RECEIVE  = 2'd0,
        MODE_READ     = 2'd1,
        MODE_RELEASE  = 2'd2,
        MODE_READ_ALT = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED      = 3'd0,
        ST_DROPPED     = 3'd1,
        ST_FULL_CLOSED = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_READ        = 3'd4,
        ST_RELEASED    = 3'd5
    } status_t;

    localparam logic [CIDX_W-1:0] CFG_TRIGGER   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ADDRESS   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CHAIN     = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_CHAIN_IRQ = 2'd3;

    localparam logic [CREG_W-1:0] TRIGGER_RESET   = 7'd8;
    localparam logic [CREG_W-1:0] ADDRESS_RESET   = 7'd8;
    localparam logic [CREG_W-1:0] CHAIN_RESET     = 7'd3;
    localparam logic [CREG_W-1:0] CHAIN_IRQ_RESET = 7'd3;

    // opcodes
    localparam logic [7:0] OPC_SMALL_FIRST = 8'd0;
    localparam logic [7:0] OPC_SMALL_LAST  = 8'd3;
    localparam logic [7:0] OPC_SHORT_BLK_A = 8'd4;
    localparam logic [7:0] OPC_SHORT_BLK_B = 8'd5;
    localparam logic [7:0] OPC_FIXED4      = 8'd6;
    localparam logic [7:0] OPC_TRIGGER     = 8'd7;
    localparam logic [7:0] OPC_ADDRESS     = 8'd8;
    localparam logic [7:0] OPC_SINGLE      = 8'd9;
    localparam logic [7:0] OPC_LONG_BLK    = 8'd10;
    localparam logic [7:0] OPC_CHAIN       = 8'd12;
    localparam logic [7:0] OPC_CHAIN_IRQ   = 8'd13;

    localparam logic [LEN_W-1:0]  SHORT_BLOCK_HDR = 18'd6;
    localparam logic [LEN_W-1:0]  LONG_BLOCK_HDR  = 18'd10;
    localparam logic [LEN_W-1:0]  FIXED4_LEN      = 18'd4;
    localparam logic [LEN_W-1:0]  SINGLE_LEN      = 18'd1;
    localparam logic [CREG_W-1:0] CHAIN_MIN_HDR   = 7'd3;
    localparam logic [3:0]        SMALL_OP_LEN [4] = '{4'd4, 4'd4, 4'd12, 4'd3};

    localparam logic [BYTE_W-1:0] FRAME_END = 8'h65;

    // record offsets of the captured header bytes
    localparam logic [CNT_W-1:0] OFS_OPCODE   = CNT_W'(0);
    localparam logic [CNT_W-1:0] OFS_THIRD    = CNT_W'(2);
    localparam logic [CNT_W-1:0] OFS_COUNT_LO = CNT_W'(4);
    localparam logic [CNT_W-1:0] OFS_COUNT_HI = CNT_W'(5);

    typedef struct packed {
        logic [CREG_W-1:0] trigger_len;
        logic [CREG_W-1:0] address_len;
        logic [CREG_W-1:0] chain_hdr;
        logic [CREG_W-1:0] chain_irq_hdr;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  third;
        logic [15:0] count;
    } rec_t;

endpackage

// ----- design/cmdfr_mem.sv -----
// ---------------------------------------------------------------------------
// cmdfr_mem
// Frame buffer: one write and one registered read port, with a bypass for
// a read issued in the same cycle as a write to that address.
// ---------------------------------------------------------------------------
module cmdfr_mem (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [cmdfr_pkg::ADDR_W-1:0] wr_addr,
    input  logic [cmdfr_pkg::BYTE_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [cmdfr_pkg::ADDR_W-1:0] rd_addr,
    output logic [cmdfr_pkg::BYTE_W-1:0] rd_data
);

    logic [cmdfr_pkg::BYTE_W-1:0] mem [cmdfr_pkg::BUFFER_DEPTH];
    logic [cmdfr_pkg::BYTE_W-1:0] q_reg;
    logic [cmdfr_pkg::BYTE_W-1:0] byp_reg;
    logic                         hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg   <= mem[rd_addr];
            byp_reg <= wr_data;
            hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = hit_reg ? byp_reg : q_reg;

endmodule

// ----- design/cmdfr_rec_len.sv -----
// ---------------------------------------------------------------------------
// cmdfr_rec_len
// Decides whether the current record is complete, from its captured header
// bytes, the length registers and the bytes received of it so far.
// ---------------------------------------------------------------------------
module cmdfr_rec_len (
    input  cmdfr_pkg::rec_t              rec,
    input  cmdfr_pkg::cfg_t              cfg,
    input  logic [cmdfr_pkg::HAVE_W-1:0] have,
    output logic                         rec_done
);

    logic [cmdfr_pkg::LEN_W-1:0]  have_ext;
    logic [cmdfr_pkg::LEN_W-1:0]  expected;
    logic [cmdfr_pkg::CREG_W-1:0] chain_h;
    logic [cmdfr_pkg::CREG_W-1:0] chain_irq_h;
    logic [cmdfr_pkg::LEN_W-1:0]  count_x2;
    logic [cmdfr_pkg::LEN_W-1:0]  third_x3;

    always_comb
    begin
        have_ext    = cmdfr_pkg::LEN_W'(have);
        chain_h     = (cfg.chain_hdr < cmdfr_pkg::CHAIN_MIN_HDR) ?
                      cmdfr_pkg::CHAIN_MIN_HDR : cfg.chain_hdr;
        chain_irq_h = (cfg.chain_irq_hdr < cmdfr_pkg::CHAIN_MIN_HDR) ?
                      cmdfr_pkg::CHAIN_MIN_HDR : cfg.chain_irq_hdr;
        count_x2    = cmdfr_pkg::LEN_W'({rec.count, 1'b0});
        third_x3    = cmdfr_pkg::LEN_W'({rec.third, 1'b0}) + cmdfr_pkg::LEN_W'(rec.third);
        expected    = '0;

        case (rec.opcode) inside
            [cmdfr_pkg::OPC_SMALL_FIRST:cmdfr_pkg::OPC_SMALL_LAST]:
                expected = cmdfr_pkg::LEN_W'(cmdfr_pkg::SMALL_OP_LEN[rec.opcode[1:0]]);
            cmdfr_pkg::OPC_SHORT_BLK_A, cmdfr_pkg::OPC_SHORT_BLK_B:
                if (have_ext >= cmdfr_pkg::SHORT_BLOCK_HDR)
                begin
                    expected = cmdfr_pkg::SHORT_BLOCK_HDR + count_x2;
                end
            cmdfr_pkg::OPC_FIXED4:
                expected = cmdfr_pkg::FIXED4_LEN;
            cmdfr_pkg::OPC_TRIGGER:
                expected = cmdfr_pkg::LEN_W'(cfg.trigger_len);
            cmdfr_pkg::OPC_ADDRESS:
                expected = cmdfr_pkg::LEN_W'(cfg.address_len);
            cmdfr_pkg::OPC_SINGLE:
                expected = cmdfr_pkg::SINGLE_LEN;
            cmdfr_pkg::OPC_LONG_BLK:
                if (have_ext >= cmdfr_pkg::LONG_BLOCK_HDR)
                begin
                    expected = cmdfr_pkg::LONG_BLOCK_HDR + count_x2;
                end
            cmdfr_pkg::OPC_CHAIN:
                if (have_ext >= cmdfr_pkg::LEN_W'(chain_h))
                begin
                    expected = cmdfr_pkg::LEN_W'(chain_h) + cmdfr_pkg::LEN_W'(rec.third);
                end
            cmdfr_pkg::OPC_CHAIN_IRQ:
                if (have_ext >= cmdfr_pkg::LEN_W'(chain_irq_h))
                begin
                    expected = cmdfr_pkg::LEN_W'(chain_irq_h) + third_x3;
                end
            // unknown opcodes never complete
            default:
                expected = '0;
        endcase

        rec_done = (expected != '0) && (have_ext >= expected);
    end

endmodule

// ----- design/command_record_framer.sv -----
// ---------------------------------------------------------------------------
// command_record_framer
// Collects serial bytes into a frame buffer, tracks whole command records,
// closes a frame on a delimiter at a record boundary or on a full buffer,
// serves indexed reads and frame release.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  ------    ---------  ---------------------   ------------------------------
//  in        sink       in_valid / in_ready     mode, rx_byte, read_index
//  out       source     out_valid / out_ready   status, frame_ready,
//                                               frame_length, complete_length,
//                                               read_data
//  cfg       sink       cfg_write (no stall)    cfg_index, cfg_data
//
//  One request per cycle is sustained while the output does not stall. A
//  request waits in the input stage (the frame buffer read is issued when
//  it is accepted) and then leaves its result in the output register; the
//  input stage is set by the registered read port of the frame buffer.
//  Reset clears counts, flags and header captures and restores the length
//  registers to their defaults; the buffer itself is not cleared, a read
//  only reaches bytes of the live frame.
//  An output stall holds the input stage; a new request is still taken while
//  a finished result waits, as long as the input stage is empty or moves on
//  that edge.
// ---------------------------------------------------------------------------
`include "command_record_framer_macros.svh"

module command_record_framer (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cmdfr_pkg::MODE_W-1:0]   mode,
    input  logic [cmdfr_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [cmdfr_pkg::INDEX_W-1:0]  read_index,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cmdfr_pkg::STATUS_W-1:0] status,
    output logic                           frame_ready,
    output logic [cmdfr_pkg::OLEN_W-1:0]   frame_length,
    output logic [cmdfr_pkg::OLEN_W-1:0]   complete_length,
    output logic [cmdfr_pkg::BYTE_W-1:0]   read_data,

    input  logic                           cfg_write,
    input  logic [cmdfr_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [cmdfr_pkg::CREG_W-1:0]   cfg_data
);

    // pipeline control
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic adv;
    logic accept;

    // input stage payload
    logic [cmdfr_pkg::MODE_W-1:0]  s1_mode_reg;
    logic [cmdfr_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic [cmdfr_pkg::INDEX_W-1:0] s1_idx_reg;

    // framer state
    logic [cmdfr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [cmdfr_pkg::CNT_W-1:0] bnd_reg, bnd_next;
    logic                        pend_reg, pend_next;
    cmdfr_pkg::rec_t             rec_reg, rec_next;
    cmdfr_pkg::cfg_t             cfg_reg, cfg_next;

    // result register
    logic [cmdfr_pkg::STATUS_W-1:0] out_status_reg;
    logic                           out_ready_flag_reg;
    logic [cmdfr_pkg::OLEN_W-1:0]   out_flen_reg;
    logic [cmdfr_pkg::OLEN_W-1:0]   out_clen_reg;
    logic [cmdfr_pkg::BYTE_W-1:0]   out_read_data_reg;

    // step logic
    cmdfr_pkg::status_t           step_status;
    logic [cmdfr_pkg::BYTE_W-1:0] step_data;
    logic [cmdfr_pkg::CNT_W-1:0]  offset;
    logic [cmdfr_pkg::HAVE_W-1:0] have;
    logic                         buf_full;
    logic                         do_store;
    logic                         rec_done;
    logic [cmdfr_pkg::BYTE_W-1:0] mem_rd_data;

    // Advance the input stage whenever the result register is free or drains.
    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
        out_valid_next = adv ? 1'b1 : ((out_valid_reg && out_ready) ? 1'b0 : out_valid_reg);
    end

    cmdfr_mem u_mem (
        .clk     (clk),
        .wr_en   (adv && do_store),
        .wr_addr (cmdfr_pkg::ADDR_W'(cnt_reg)),
        .wr_data (s1_byte_reg),
        .rd_en   (accept),
        .rd_addr (cmdfr_pkg::ADDR_W'(read_index)),
        .rd_data (mem_rd_data)
    );

    assign offset = cnt_reg - bnd_reg;
    assign have   = cmdfr_pkg::HAVE_W'(offset) + cmdfr_pkg::HAVE_W'(1);
    assign buf_full = cnt_reg >= cmdfr_pkg::CNT_W'(cmdfr_pkg::BUFFER_DEPTH - 1);

    // Capture opcode, third byte and count field at their record offsets.
    always_comb
    begin
        rec_next = rec_reg;
        case (offset)
            cmdfr_pkg::OFS_OPCODE:   rec_next.opcode      = s1_byte_reg;
            cmdfr_pkg::OFS_THIRD:    rec_next.third       = s1_byte_reg;
            cmdfr_pkg::OFS_COUNT_LO: rec_next.count[7:0]  = s1_byte_reg;
            cmdfr_pkg::OFS_COUNT_HI: rec_next.count[15:8] = s1_byte_reg;
            default:                 rec_next             = rec_reg;
        endcase
    end

    // The decision uses the captures as updated by this byte.
    cmdfr_rec_len u_rec_len (
        .rec      (rec_next),
        .cfg      (cfg_reg),
        .have     (have),
        .rec_done (rec_done)
    );

    // One step of the framer for the request in the input stage.
    always_comb
    begin
        cnt_next    = cnt_reg;
        bnd_next    = bnd_reg;
        pend_next   = pend_reg;
        do_store    = 1'b0;
        step_data   = '0;
        step_status = cmdfr_pkg::ST_READ;

        case (s1_mode_reg)
            cmdfr_pkg::MODE_RECEIVE:
            begin
                if (pend_reg)
                begin
                    // drop bytes while a frame waits for software
                    step_status = cmdfr_pkg::ST_DROPPED;
                end
                else if (buf_full)
                begin
                    if (bnd_reg != '0)
                    begin
                        // close on the whole records held so far
                        pend_next   = 1'b1;
                        step_status = cmdfr_pkg::ST_FULL_CLOSED;
                    end
                    else
                    begin
                        // no whole record: drop the partial frame
                        cnt_next    = '0;
                        bnd_next    = '0;
                        step_status = cmdfr_pkg::ST_OVERFLOW;
                    end
                end
                else
                begin
                    do_store    = 1'b1;
                    cnt_next    = cnt_reg + cmdfr_pkg::CNT_W'(1);
                    step_status = cmdfr_pkg::ST_STORED;
                    if (rec_done)
                    begin
                        bnd_next = cnt_next;
                    end
                    // delimiter only counts when it starts on a boundary
                    if (s1_byte_reg == cmdfr_pkg::FRAME_END && bnd_next == cnt_reg)
                    begin
                        pend_next = 1'b1;
                    end
                end
            end
            cmdfr_pkg::MODE_RELEASE:
            begin
                cnt_next    = '0;
                bnd_next    = '0;
                pend_next   = 1'b0;
                step_status = cmdfr_pkg::ST_RELEASED;
            end
            cmdfr_pkg::MODE_READ, cmdfr_pkg::MODE_READ_ALT:
            begin
                step_status = cmdfr_pkg::ST_READ;
                if (cmdfr_pkg::CMP_W'(s1_idx_reg) < cmdfr_pkg::CMP_W'(cnt_reg))
                begin
                    step_data = mem_rd_data;
                end
            end
            default:
            begin
                step_status = cmdfr_pkg::ST_READ;
            end
        endcase
    end

    // Length registers: the user must write them only while the block is idle; the block itself does not enforce it.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                cmdfr_pkg::CFG_TRIGGER:   cfg_next.trigger_len   = cfg_data;
                cmdfr_pkg::CFG_ADDRESS:   cfg_next.address_len   = cfg_data;
                cmdfr_pkg::CFG_CHAIN:     cfg_next.chain_hdr     = cfg_data;
                cmdfr_pkg::CFG_CHAIN_IRQ: cfg_next.chain_irq_hdr = cfg_data;
                default:                  cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            cnt_reg               <= '0;
            bnd_reg               <= '0;
            pend_reg              <= 1'b0;
            rec_reg               <= '0;
            cfg_reg.trigger_len   <= cmdfr_pkg::TRIGGER_RESET;
            cfg_reg.address_len   <= cmdfr_pkg::ADDRESS_RESET;
            cfg_reg.chain_hdr     <= cmdfr_pkg::CHAIN_RESET;
            cfg_reg.chain_irq_hdr <= cmdfr_pkg::CHAIN_IRQ_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            if (adv)
            begin
                cnt_reg  <= cnt_next;
                bnd_reg  <= bnd_next;
                pend_reg <= pend_next;
                if (do_store)
                begin
                    rec_reg <= rec_next;
                end
            end
        end
    end

    // Payload registers: hold the request and the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= mode;
            s1_byte_reg <= rx_byte;
            s1_idx_reg  <= read_index;
        end
        if (adv)
        begin
            out_status_reg     <= step_status;
            out_ready_flag_reg <= pend_next;
            out_flen_reg       <= cmdfr_pkg::OLEN_W'(cnt_next);
            out_clen_reg       <= cmdfr_pkg::OLEN_W'(bnd_next);
            out_read_data_reg  <= step_data;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign frame_ready     = out_ready_flag_reg;
    assign frame_length    = out_flen_reg;
    assign complete_length = out_clen_reg;
    assign read_data       = out_read_data_reg;

    // The record boundary never runs ahead of the stored bytes.
    `CMDFR_ASSERT_IMP(a_bnd_le_cnt, 1'b1, bnd_reg <= cnt_reg)

    // A pending frame takes no more bytes.
    `CMDFR_ASSERT_NEXT(a_pend_hold,
        adv && pend_reg && (s1_mode_reg == cmdfr_pkg::MODE_RECEIVE),
        $stable(cnt_reg) && $stable(bnd_reg) && pend_reg)

    // Release empties the buffer and drops the pending flag.
    `CMDFR_ASSERT_NEXT(a_release_clears,
        adv && (s1_mode_reg == cmdfr_pkg::MODE_RELEASE),
        (cnt_reg == '0) && (bnd_reg == '0) && !pend_reg)

    // Only read results carry data.
    `CMDFR_ASSERT_IMP(a_data_only_on_read,
        out_valid_reg && (out_status_reg != cmdfr_pkg::ST_READ),
        out_read_data_reg == '0)

endmodule
